@@ rtl/countdown_event_timer_bank_defines.svh @@
// assertion macros for the countdown event timer bank
// used by the bound checker; depends on nothing

`ifndef COUNTDOWN_EVENT_TIMER_BANK_DEFINES_SVH
`define COUNTDOWN_EVENT_TIMER_BANK_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define CETB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define CETB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cetb_pkg.sv @@
// shared types and constants for the countdown event timer bank
// no dependencies

package cetb_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MaxResults  = 16;
	localparam int FUNC_W      = 2;
	localparam int DATA_W      = 16;
	localparam int SLOT_W      = 4;
	localparam int STATUS_W    = 3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_TICK   = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED      = 3'd0,
		ST_FULL       = 3'd1,
		ST_REMOVED    = 3'd2,
		ST_NOT_ACTIVE = 3'd3,
		ST_FIRED      = 3'd4,
		ST_INVALID    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RM_RD,
		S_SCAN,
		S_EVAL,
		S_FLUSH
	} ctl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic add;
		logic rm_start;
		logic rm_finish;
		logic tick_start;
		logic scan_next;
		logic eval;
		logic flush;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic idx_active;
		logic idx_last;
		logic eval_block;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/cetb_stream_if.sv @@
// valid/ready stream interfaces for the input and result channels
// depends on cetb_pkg

interface cetb_in_if;
	logic                           valid;
	logic                           ready;
	logic [cetb_pkg::FUNC_W-1:0]    func;
	logic [cetb_pkg::DATA_W-1:0]    delay;
	logic [cetb_pkg::DATA_W-1:0]    tag;
	logic [cetb_pkg::SLOT_W-1:0]    slot;

	modport source (output valid, func, delay, tag, slot, input ready);
	modport sink (input valid, func, delay, tag, slot, output ready);
endinterface

interface cetb_out_if;
	logic                           valid;
	logic                           ready;
	logic [cetb_pkg::STATUS_W-1:0]  status;
	logic [cetb_pkg::SLOT_W-1:0]    slot_out;
	logic [cetb_pkg::DATA_W-1:0]    tag_out;
	logic                           last;

	modport source (output valid, status, slot_out, tag_out, last, input ready);
	modport sink (input valid, status, slot_out, tag_out, last, output ready);
endinterface

@@ rtl/cetb_ctrl.sv @@
// controller state machine of the timer bank: sequences add, remove and tick scans
// depends on cetb_pkg

module cetb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [cetb_pkg::FUNC_W-1:0] in_func,
	output logic                        in_ready,
	input  cetb_pkg::sts_t              sts,
	output cetb_pkg::cmd_t              cmd
);

	cetb_pkg::ctl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cetb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cetb_pkg::S_IDLE: begin
				if (in_valid) begin
					case (cetb_pkg::func_t'(in_func))
						cetb_pkg::FUNC_ADD:    state_d = cetb_pkg::S_FLUSH;
						cetb_pkg::FUNC_REMOVE: state_d = cetb_pkg::S_RM_RD;
						cetb_pkg::FUNC_TICK:   state_d = cetb_pkg::S_SCAN;
						default:               state_d = cetb_pkg::S_IDLE;
					endcase
				end
			end
			cetb_pkg::S_RM_RD: begin
				state_d = cetb_pkg::S_FLUSH;
			end
			cetb_pkg::S_SCAN: begin
				if (sts.idx_active) begin
					state_d = cetb_pkg::S_EVAL;
				end else if (sts.idx_last) begin
					state_d = cetb_pkg::S_FLUSH;
				end
			end
			cetb_pkg::S_EVAL: begin
				if (!sts.eval_block) begin
					state_d = sts.idx_last ? cetb_pkg::S_FLUSH : cetb_pkg::S_SCAN;
				end
			end
			cetb_pkg::S_FLUSH: begin
				if (!sts.pend_valid || sts.out_free) begin
					state_d = cetb_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cetb_pkg::S_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			cetb_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (cetb_pkg::func_t'(in_func))
						cetb_pkg::FUNC_ADD:    cmd.add        = 1'b1;
						cetb_pkg::FUNC_REMOVE: cmd.rm_start   = 1'b1;
						cetb_pkg::FUNC_TICK:   cmd.tick_start = 1'b1;
						default:               cmd            = '0;
					endcase
				end
			end
			cetb_pkg::S_RM_RD: begin
				cmd.rm_finish = 1'b1;
			end
			cetb_pkg::S_SCAN: begin
				cmd.scan_next = !sts.idx_active && !sts.idx_last;
			end
			cetb_pkg::S_EVAL: begin
				cmd.eval      = !sts.eval_block;
				cmd.scan_next = !sts.eval_block && !sts.idx_last;
			end
			cetb_pkg::S_FLUSH: begin
				cmd.flush = sts.pend_valid && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/cetb_dp.sv @@
// datapath of the timer bank: active bits, delay and tag memories,
// scan index, held-back result and output register
// depends on cetb_pkg

module cetb_dp #(
	parameter int SLOTS = cetb_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cetb_pkg::cmd_t                cmd,
	output cetb_pkg::sts_t                sts,
	input  logic [cetb_pkg::DATA_W-1:0]   delay,
	input  logic [cetb_pkg::DATA_W-1:0]   tag,
	input  logic [cetb_pkg::SLOT_W-1:0]   slot,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [cetb_pkg::STATUS_W-1:0] status,
	output logic [cetb_pkg::SLOT_W-1:0]   slot_out,
	output logic [cetb_pkg::DATA_W-1:0]   tag_out,
	output logic                          last
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(cetb_pkg::MaxResults + 1);

	logic [SLOTS-1:0]              active_q;
	logic [cetb_pkg::DATA_W-1:0]   rem_mem_q [SLOTS];
	logic [cetb_pkg::DATA_W-1:0]   tag_mem_q [SLOTS];
	logic [cetb_pkg::DATA_W-1:0]   rem_rd_q;
	logic [cetb_pkg::DATA_W-1:0]   tag_rd_q;
	logic [IDX_W-1:0]              idx_q;
	logic [CNT_W-1:0]              fire_cnt_q;

	logic                          pend_valid_q;
	cetb_pkg::status_t             pend_status_q;
	logic [cetb_pkg::SLOT_W-1:0]   pend_slot_q;
	logic [cetb_pkg::DATA_W-1:0]   pend_tag_q;

	logic                          out_valid_q;
	cetb_pkg::status_t             out_status_q;
	logic [cetb_pkg::SLOT_W-1:0]   out_slot_q;
	logic [cetb_pkg::DATA_W-1:0]   out_tag_q;
	logic                          out_last_q;

	logic                          free_found;
	logic [IDX_W-1:0]              free_idx;
	logic                          add_ok;
	logic [IDX_W-1:0]              rm_idx;
	logic                          rm_hit;
	logic                          fire;
	logic                          cap_ok;
	logic                          eval_fire;
	logic                          out_free;
	logic                          push;
	logic [IDX_W-1:0]              rd_addr;
	logic                          rem_we;
	logic [IDX_W-1:0]              rem_waddr;
	logic [cetb_pkg::DATA_W-1:0]   rem_wdata;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	assign add_ok = (delay != '0) && free_found;

	// remove lookup
	assign rm_idx = IDX_W'(slot);
	assign rm_hit = (32'(slot) < SLOTS) && active_q[rm_idx];

	// tick evaluation of the slot under the scan index
	assign fire      = rem_rd_q <= cetb_pkg::DATA_W'(1);
	assign cap_ok    = fire_cnt_q < CNT_W'(cetb_pkg::MaxResults);
	assign eval_fire = fire && cap_ok;

	assign out_free = !out_valid_q || out_ready;
	assign push     = (cmd.eval && eval_fire && pend_valid_q) || cmd.flush;

	assign sts.idx_active = active_q[idx_q];
	assign sts.idx_last   = idx_q == IDX_W'(SLOTS - 1);
	assign sts.eval_block = eval_fire && pend_valid_q && !out_free;
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

	// remaining-count write port
	always_comb begin
		rem_we    = 1'b0;
		rem_waddr = idx_q;
		rem_wdata = rem_rd_q - cetb_pkg::DATA_W'(1);
		if (cmd.add) begin
			rem_we    = add_ok;
			rem_waddr = free_idx;
			rem_wdata = delay;
		end else if (cmd.eval) begin
			if (!fire) begin
				rem_we = 1'b1;
			end else if (!cap_ok) begin
				rem_we    = 1'b1;
				rem_wdata = cetb_pkg::DATA_W'(1);
			end
		end
	end

	assign rd_addr = cmd.rm_start ? rm_idx : idx_q;

	// delay and tag memories, registered read
	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem_q[rem_waddr] <= rem_wdata;
		end
		if (cmd.add && add_ok) begin
			tag_mem_q[free_idx] <= tag;
		end
		rem_rd_q <= rem_mem_q[rd_addr];
		tag_rd_q <= tag_mem_q[rd_addr];
	end

	// active bits, scan index and fire count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			idx_q      <= '0;
			fire_cnt_q <= '0;
		end else begin
			if (cmd.add && add_ok) begin
				active_q[free_idx] <= 1'b1;
			end
			if (cmd.rm_start && rm_hit) begin
				active_q[rm_idx] <= 1'b0;
			end
			if (cmd.eval && eval_fire) begin
				active_q[idx_q] <= 1'b0;
				fire_cnt_q      <= fire_cnt_q + CNT_W'(1);
			end
			if (cmd.tick_start) begin
				idx_q      <= '0;
				fire_cnt_q <= '0;
			end else if (cmd.scan_next) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// held-back result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.add || cmd.rm_start || (cmd.eval && eval_fire)) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.flush) begin
			pend_valid_q <= 1'b0;
		end
	end

	// held-back result payload
	always_ff @(posedge clk) begin
		if (cmd.add) begin
			pend_tag_q <= '0;
			if (delay == '0) begin
				pend_status_q <= cetb_pkg::ST_INVALID;
				pend_slot_q   <= '0;
			end else if (free_found) begin
				pend_status_q <= cetb_pkg::ST_ADDED;
				pend_slot_q   <= cetb_pkg::SLOT_W'(free_idx);
			end else begin
				pend_status_q <= cetb_pkg::ST_FULL;
				pend_slot_q   <= '0;
			end
		end else if (cmd.rm_start) begin
			pend_tag_q    <= '0;
			pend_status_q <= rm_hit ? cetb_pkg::ST_REMOVED : cetb_pkg::ST_NOT_ACTIVE;
			pend_slot_q   <= rm_hit ? slot : '0;
		end else if (cmd.rm_finish) begin
			if (pend_status_q == cetb_pkg::ST_REMOVED) begin
				pend_tag_q <= tag_rd_q;
			end
		end else if (cmd.eval && eval_fire) begin
			pend_status_q <= cetb_pkg::ST_FIRED;
			pend_slot_q   <= cetb_pkg::SLOT_W'(idx_q);
			pend_tag_q    <= tag_rd_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload; only the final push of an item is marked last
	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q <= pend_status_q;
			out_slot_q   <= pend_slot_q;
			out_tag_q    <= pend_tag_q;
			out_last_q   <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign slot_out  = out_slot_q;
	assign tag_out   = out_tag_q;
	assign last      = out_last_q;

endmodule

@@ rtl/countdown_event_timer_bank.sv @@
// top level of the countdown event timer bank
// depends on cetb_pkg, cetb_stream_if, cetb_ctrl and cetb_dp

// A bank of SLOTS one-shot timers behind valid/ready streams. An add claims
// the lowest free slot (status added/full/invalid delay), a remove cancels a
// slot and returns its tag, and a tick decrements every active timer and
// reports each one that expires, in ascending slot order, with last set on
// the final result; a tick that fires nothing gives no result. At most 16
// timers fire per tick, later expired ones fire on the next tick. One item is
// worked at a time: an add passes through idle and flush, a remove through
// idle, tag read and flush, and a tick scans each slot in turn, with an
// extra evaluation step for each active slot, over the single read port of
// the delay and tag memories; result-side stalls hold evaluation and flush.

module countdown_event_timer_bank #(
	parameter int SLOTS = cetb_pkg::SLOTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	cetb_in_if.sink     in_ch,
	cetb_out_if.source  out_ch
);

	cetb_pkg::cmd_t                cmd;
	cetb_pkg::sts_t                sts;
	logic                          in_ready;
	logic                          out_valid;
	logic [cetb_pkg::STATUS_W-1:0] status;
	logic [cetb_pkg::SLOT_W-1:0]   slot_out;
	logic [cetb_pkg::DATA_W-1:0]   tag_out;
	logic                          last;

	// sequencing
	cetb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_func  (in_ch.func),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and result path
	cetb_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.delay     (in_ch.delay),
		.tag       (in_ch.tag),
		.slot      (in_ch.slot),
		.out_ready (out_ch.ready),
		.out_valid (out_valid),
		.status    (status),
		.slot_out  (slot_out),
		.tag_out   (tag_out),
		.last      (last)
	);

	assign in_ch.ready     = in_ready;
	assign out_ch.valid    = out_valid;
	assign out_ch.status   = status;
	assign out_ch.slot_out = slot_out;
	assign out_ch.tag_out  = tag_out;
	assign out_ch.last     = last;

endmodule

@@ rtl/cetb_checker.sv @@
// port-level checker for the timer bank and its bind to the top level
// depends on cetb_pkg and countdown_event_timer_bank_defines.svh

`include "countdown_event_timer_bank_defines.svh"

module cetb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [cetb_pkg::FUNC_W-1:0]   in_func,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [cetb_pkg::STATUS_W-1:0] out_status,
	input logic [cetb_pkg::SLOT_W-1:0]   out_slot,
	input logic [cetb_pkg::DATA_W-1:0]   out_tag,
	input logic                          out_last
);

	// a real item keeps the input closed while it is worked
	`CETB_ASSERT_NEXT(a_busy_after_item, clk, arst_n, in_valid && in_ready && (in_func == cetb_pkg::FUNC_ADD || in_func == cetb_pkg::FUNC_REMOVE || in_func == cetb_pkg::FUNC_TICK), !in_ready, "input ready right after an item")

	// a stalled result holds
	`CETB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_slot) && $stable(out_tag) && $stable(out_last), "stalled result changed")

	// add and remove answers are single results
	`CETB_ASSERT_SAME(a_single_last, clk, arst_n, out_valid && out_status != cetb_pkg::ST_FIRED, out_last, "add or remove result without last")

	// rejections carry no slot and no tag
	`CETB_ASSERT_SAME(a_reject_zero, clk, arst_n, out_valid && (out_status == cetb_pkg::ST_FULL || out_status == cetb_pkg::ST_NOT_ACTIVE || out_status == cetb_pkg::ST_INVALID), out_slot == '0 && out_tag == '0, "rejection with slot or tag")

endmodule

bind countdown_event_timer_bank cetb_checker u_cetb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_func    (in_ch.func),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_status (out_ch.status),
	.out_slot   (out_ch.slot_out),
	.out_tag    (out_ch.tag_out),
	.out_last   (out_ch.last)
);
